// ===== hdl/mmcd_pkg.sv =====
package mmcd_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_MODE = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_NOISE_SPAN   = 2'd3;

    localparam int SAMPLE_COUNT_W = 16;
    localparam int COLUMN_COUNT_W = 12;
    localparam int NOISE_SPAN_W   = 12;
    localparam int COL_INDEX_W    = 11;

    localparam logic [SAMPLE_COUNT_W-1:0] SAMPLE_COUNT_RST = 16'd2500;
    localparam logic [COLUMN_COUNT_W-1:0] COLUMN_COUNT_RST = 12'd1024;
    localparam logic                      DISPLAY_MODE_RST = 1'b0;
    localparam logic [NOISE_SPAN_W-1:0]   NOISE_SPAN_RST   = 12'd4000;

    typedef enum logic [2:0] {
        ST_BND,
        ST_BND_WAIT,
        ST_RUN,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic div_bnd;
        logic frame_init;
        logic sample_acc;
        logic close_direct;
        logic div_mean;
        logic emit_mean;
    } ctrl_cmd_t;

    typedef struct packed {
        logic restart;
        logic close;
        logic avg;
        logic out_free;
        logic div_busy;
        logic div_done;
    } dp_status_t;

endpackage

// ===== hdl/minmax_column_decimator_core.sv =====
// channel    dir  handshake                      payload
// s_axis     in   s_axis_tvalid / s_axis_tready  tdata: sample
// m_axis     out  m_axis_tvalid / m_axis_tready  tdata: column_index, column_min,
//                                                column_max, column_mean;
//                                                tlast: last_column; tuser: rail_noise
// cfg        in   cfg_write (no wait)            cfg_index, cfg_data
//
// one sample per cycle; a column that closes in envelope mode is issued at once
// in average mode each column closure stalls input while the iterative divider
// forms the mean
// after reset and after a write to sample_count or column_count, input is held
// while the same divider computes the column step
// while a result waits, input stops at the next sample that closes a column
module minmax_column_decimator_core #(
    parameter int SAMPLE_BITS       = 12,
    parameter int MAX_COLUMNS       = 2048,
    parameter int MAX_FRAME_SAMPLES = 65535
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,   // sample
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // column_index, column_min, column_max, column_mean
    output logic [((mmcd_pkg::COL_INDEX_W + 3 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic                             m_axis_tlast,   // last_column
    output logic                             m_axis_tuser,   // rail_noise
    input  logic                             cfg_write,
    input  logic [mmcd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mmcd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int PACK_W = mmcd_pkg::COL_INDEX_W + 3 * SAMPLE_BITS;
    localparam int OUT_W  = ((PACK_W + 7) / 8) * 8;

    mmcd_pkg::ctrl_cmd_t  cmd;
    mmcd_pkg::dp_status_t status;

    logic [mmcd_pkg::COL_INDEX_W-1:0] out_index;
    logic [SAMPLE_BITS-1:0]           out_min;
    logic [SAMPLE_BITS-1:0]           out_max;
    logic [SAMPLE_BITS-1:0]           out_mean;

    mmcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    mmcd_dp #(
        .SAMPLE_BITS       (SAMPLE_BITS),
        .MAX_COLUMNS       (MAX_COLUMNS),
        .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_index (out_index),
        .out_min   (out_min),
        .out_max   (out_max),
        .out_mean  (out_mean),
        .out_last  (m_axis_tlast),
        .out_rail  (m_axis_tuser)
    );

    assign s_axis_tready = cmd.in_ready;
    assign m_axis_tdata  = OUT_W'({out_mean, out_max, out_min, out_index});

    // no sample may be taken while the divider is still working
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !status.div_busy)
    else $error("sample accepted while divider busy");

    // a result is only loaded into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.close_direct || cmd.emit_mean) |-> status.out_free)
    else $error("result register overwritten before transfer");

    // rail noise is only reported on the final column
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("rail noise flagged on a non-final column");

    // the mean path always waits for the divider result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_mean |-> !status.div_busy && status.avg)
    else $error("mean issued without a finished division");

endmodule

// ===== hdl/mmcd_div.sv =====
module mmcd_div #(
    parameter int W    = 32,
    parameter int DV_W = 16,
    parameter int QW   = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [W-1:0]    dividend,
    input  logic [DV_W-1:0] divisor,
    output logic [QW-1:0]   quotient,
    output logic [DV_W-1:0] remainder,
    output logic            busy,
    output logic            done
);

    localparam int CTR_W = (QW > 1) ? $clog2(QW) : 1;

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     dsh_reg, dsh_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic [CTR_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             ge;

    // one quotient bit per cycle, divisor shifted down from the top bit
    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        ge        = (rem_reg >= dsh_reg);
        if (start)
        begin
            rem_next  = dividend;
            dsh_next  = W'(divisor) << (QW - 1);
            quo_next  = '0;
            cnt_next  = CTR_W'(QW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            quo_next = {quo_reg[QW-2:0], ge};
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg[DV_W-1:0];
    assign busy      = busy_reg;
    assign done      = done_reg;

endmodule

// ===== hdl/mmcd_ctrl.sv =====
module mmcd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  mmcd_pkg::dp_status_t   status,
    output mmcd_pkg::ctrl_cmd_t    cmd
);

    mmcd_pkg::state_t state_reg, state_next;
    logic             accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mmcd_pkg::ST_BND;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        accept     = 1'b0;
        case (state_reg)
            mmcd_pkg::ST_BND:
            begin
                cmd.div_bnd = 1'b1;
                state_next  = mmcd_pkg::ST_BND_WAIT;
            end
            mmcd_pkg::ST_BND_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.frame_init = 1'b1;
                    state_next     = mmcd_pkg::ST_RUN;
                end
            end
            mmcd_pkg::ST_RUN:
            begin
                // a closing sample in envelope mode needs the output register free
                cmd.in_ready = !(status.close && !status.avg && !status.out_free);
                accept       = in_valid && cmd.in_ready;
                cmd.sample_acc = accept;
                if (accept && status.close)
                begin
                    if (status.avg)
                    begin
                        state_next = mmcd_pkg::ST_MEAN_GO;
                    end
                    else
                    begin
                        cmd.close_direct = 1'b1;
                    end
                end
            end
            mmcd_pkg::ST_MEAN_GO:
            begin
                cmd.div_mean = 1'b1;
                state_next   = mmcd_pkg::ST_MEAN_WAIT;
            end
            mmcd_pkg::ST_MEAN_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = mmcd_pkg::ST_EMIT;
                end
            end
            mmcd_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_mean = 1'b1;
                    state_next    = mmcd_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = mmcd_pkg::ST_BND;
            end
        endcase
        // new frame geometry: recompute the column step
        if (status.restart)
        begin
            state_next = mmcd_pkg::ST_BND;
        end
    end

endmodule

// ===== hdl/mmcd_dp.sv =====
module mmcd_dp #(
    parameter int SAMPLE_BITS       = 12,
    parameter int MAX_COLUMNS       = 2048,
    parameter int MAX_FRAME_SAMPLES = 65535
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [mmcd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mmcd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  mmcd_pkg::ctrl_cmd_t              cmd,
    output mmcd_pkg::dp_status_t             status,
    input  logic [SAMPLE_BITS-1:0]           sample,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [mmcd_pkg::COL_INDEX_W-1:0] out_index,
    output logic [SAMPLE_BITS-1:0]           out_min,
    output logic [SAMPLE_BITS-1:0]           out_max,
    output logic [SAMPLE_BITS-1:0]           out_mean,
    output logic                             out_last,
    output logic                             out_rail
);

    localparam int FRAME_W = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int CNT_W   = $clog2(MAX_COLUMNS + 1);
    localparam int IDX_W   = $clog2(MAX_COLUMNS);
    localparam int SUM_W   = FRAME_W + SAMPLE_BITS;
    localparam int QW      = (FRAME_W > SAMPLE_BITS) ? FRAME_W : SAMPLE_BITS;
    localparam int DIV_W   = FRAME_W + QW;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_ONES = '1;

    // configuration
    logic [mmcd_pkg::SAMPLE_COUNT_W-1:0] sample_count_reg;
    logic [mmcd_pkg::COLUMN_COUNT_W-1:0] column_count_reg;
    logic                                display_mode_reg;
    logic [mmcd_pkg::NOISE_SPAN_W-1:0]   noise_span_reg;

    // frame state
    logic [FRAME_W-1:0]     frame_cnt_reg, frame_cnt_next;
    logic [IDX_W-1:0]       col_reg, col_next;
    logic [CNT_W-1:0]       brem_reg, brem_next;
    logic [FRAME_W-1:0]     bend_reg, bend_next;
    logic [FRAME_W-1:0]     step_q_reg, step_q_next;
    logic [CNT_W-1:0]       step_r_reg, step_r_next;
    logic [SAMPLE_BITS-1:0] bmin_reg, bmin_next;
    logic [SAMPLE_BITS-1:0] bmax_reg, bmax_next;
    logic [SUM_W-1:0]       bsum_reg, bsum_next;
    logic [FRAME_W-1:0]     bsize_reg, bsize_next;
    logic [SAMPLE_BITS-1:0] fmin_reg, fmin_next;
    logic [SAMPLE_BITS-1:0] fmax_reg, fmax_next;

    // result register
    logic                             out_valid_reg, out_valid_next;
    logic [mmcd_pkg::COL_INDEX_W-1:0] out_index_reg, out_index_next;
    logic [SAMPLE_BITS-1:0]           out_min_reg, out_min_next;
    logic [SAMPLE_BITS-1:0]           out_max_reg, out_max_next;
    logic [SAMPLE_BITS-1:0]           out_mean_reg, out_mean_next;
    logic                             out_last_reg, out_last_next;
    logic                             out_rail_reg, out_rail_next;

    logic [31:0]            s_raw, c_raw;
    logic [FRAME_W-1:0]     eff_s;
    logic [CNT_W-1:0]       eff_c;
    logic                   last;
    logic                   close;
    logic [CNT_W:0]         rem_sum;
    logic                   wrap;
    logic [SAMPLE_BITS-1:0] upd_bmin, upd_bmax, upd_fmin, upd_fmax;
    logic [SAMPLE_BITS-1:0] src_bmin, src_bmax, src_fmin, src_fmax;
    logic [SAMPLE_BITS-1:0] span;
    logic                   rail;
    logic                   load;

    logic                   div_start;
    logic [DIV_W-1:0]       div_dividend;
    logic [FRAME_W-1:0]     div_divisor;
    logic [QW-1:0]          div_q;
    logic [FRAME_W-1:0]     div_r;
    logic                   div_busy;
    logic                   div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= mmcd_pkg::SAMPLE_COUNT_RST;
            column_count_reg <= mmcd_pkg::COLUMN_COUNT_RST;
            display_mode_reg <= mmcd_pkg::DISPLAY_MODE_RST;
            noise_span_reg   <= mmcd_pkg::NOISE_SPAN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mmcd_pkg::REG_SAMPLE_COUNT:
                    sample_count_reg <= cfg_data[mmcd_pkg::SAMPLE_COUNT_W-1:0];
                mmcd_pkg::REG_COLUMN_COUNT:
                    column_count_reg <= cfg_data[mmcd_pkg::COLUMN_COUNT_W-1:0];
                mmcd_pkg::REG_DISPLAY_MODE:
                    display_mode_reg <= cfg_data[0];
                mmcd_pkg::REG_NOISE_SPAN:
                    noise_span_reg <= cfg_data[mmcd_pkg::NOISE_SPAN_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // effective sample and column counts
    always_comb
    begin
        s_raw = 32'(sample_count_reg);
        if (s_raw == 32'd0)
        begin
            s_raw = 32'd1;
        end
        if (s_raw > 32'(MAX_FRAME_SAMPLES))
        begin
            s_raw = 32'(MAX_FRAME_SAMPLES);
        end
        c_raw = 32'(column_count_reg);
        if (c_raw == 32'd0)
        begin
            c_raw = 32'd1;
        end
        if (c_raw > 32'(MAX_COLUMNS))
        begin
            c_raw = 32'(MAX_COLUMNS);
        end
        if (c_raw > s_raw)
        begin
            c_raw = s_raw;
        end
    end

    assign eff_s = FRAME_W'(s_raw);
    assign eff_c = CNT_W'(c_raw);

    assign last  = ((CNT_W + 1)'(col_reg) + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(eff_c);
    assign close = ((FRAME_W + 1)'(frame_cnt_reg) + (FRAME_W + 1)'(1))
                   >= (FRAME_W + 1)'(bend_reg);

    // next column boundary
    assign rem_sum = (CNT_W + 1)'(brem_reg) + (CNT_W + 1)'(step_r_reg);
    assign wrap    = rem_sum >= (CNT_W + 1)'(eff_c);

    assign upd_bmin = (sample < bmin_reg) ? sample : bmin_reg;
    assign upd_bmax = (sample > bmax_reg) ? sample : bmax_reg;
    assign upd_fmin = (sample < fmin_reg) ? sample : fmin_reg;
    assign upd_fmax = (sample > fmax_reg) ? sample : fmax_reg;

    assign src_bmin = cmd.emit_mean ? bmin_reg : upd_bmin;
    assign src_bmax = cmd.emit_mean ? bmax_reg : upd_bmax;
    assign src_fmin = cmd.emit_mean ? fmin_reg : upd_fmin;
    assign src_fmax = cmd.emit_mean ? fmax_reg : upd_fmax;

    assign span = src_fmax - src_fmin;
    assign rail = last && (src_fmax >= src_fmin) && (32'(span) > 32'(noise_span_reg));
    assign load = cmd.close_direct || cmd.emit_mean;

    always_comb
    begin
        frame_cnt_next = frame_cnt_reg;
        col_next       = col_reg;
        brem_next      = brem_reg;
        bend_next      = bend_reg;
        step_q_next    = step_q_reg;
        step_r_next    = step_r_reg;
        bmin_next      = bmin_reg;
        bmax_next      = bmax_reg;
        bsum_next      = bsum_reg;
        bsize_next     = bsize_reg;
        fmin_next      = fmin_reg;
        fmax_next      = fmax_reg;

        out_valid_next = out_valid_reg && !out_ready;
        out_index_next = out_index_reg;
        out_min_next   = out_min_reg;
        out_max_next   = out_max_reg;
        out_mean_next  = out_mean_reg;
        out_last_next  = out_last_reg;
        out_rail_next  = out_rail_reg;

        if (cmd.sample_acc)
        begin
            frame_cnt_next = frame_cnt_reg + 1'b1;
            bmin_next      = upd_bmin;
            bmax_next      = upd_bmax;
            fmin_next      = upd_fmin;
            fmax_next      = upd_fmax;
            bsum_next      = bsum_reg + SUM_W'(sample);
            bsize_next     = bsize_reg + 1'b1;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
            out_index_next = mmcd_pkg::COL_INDEX_W'(col_reg);
            out_min_next   = src_bmin;
            out_max_next   = src_bmax;
            out_mean_next  = cmd.emit_mean ? SAMPLE_BITS'(div_q) : '0;
            out_last_next  = last;
            out_rail_next  = rail;

            bmin_next  = SAMPLE_ONES;
            bmax_next  = '0;
            bsum_next  = '0;
            bsize_next = '0;
            if (last)
            begin
                frame_cnt_next = '0;
                col_next       = '0;
                bend_next      = step_q_reg;
                brem_next      = step_r_reg;
                fmin_next      = SAMPLE_ONES;
                fmax_next      = '0;
            end
            else
            begin
                col_next  = col_reg + 1'b1;
                bend_next = bend_reg + step_q_reg + FRAME_W'(wrap);
                brem_next = wrap ? CNT_W'(rem_sum - (CNT_W + 1)'(eff_c)) : CNT_W'(rem_sum);
            end
        end

        if (cmd.frame_init)
        begin
            step_q_next    = FRAME_W'(div_q);
            step_r_next    = CNT_W'(div_r);
            frame_cnt_next = '0;
            col_next       = '0;
            bend_next      = FRAME_W'(div_q);
            brem_next      = CNT_W'(div_r);
            bmin_next      = SAMPLE_ONES;
            bmax_next      = '0;
            bsum_next      = '0;
            bsize_next     = '0;
            fmin_next      = SAMPLE_ONES;
            fmax_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_cnt_reg <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            frame_cnt_reg <= frame_cnt_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        brem_reg      <= brem_next;
        bend_reg      <= bend_next;
        step_q_reg    <= step_q_next;
        step_r_reg    <= step_r_next;
        bmin_reg      <= bmin_next;
        bmax_reg      <= bmax_next;
        bsum_reg      <= bsum_next;
        bsize_reg     <= bsize_next;
        fmin_reg      <= fmin_next;
        fmax_reg      <= fmax_next;
        out_index_reg <= out_index_next;
        out_min_reg   <= out_min_next;
        out_max_reg   <= out_max_next;
        out_mean_reg  <= out_mean_next;
        out_last_reg  <= out_last_next;
        out_rail_reg  <= out_rail_next;
    end

    // shared divider: column step at frame setup, bucket mean per column in average mode
    assign div_start    = cmd.div_bnd || cmd.div_mean;
    assign div_dividend = cmd.div_mean ? DIV_W'(bsum_reg) : DIV_W'(eff_s);
    assign div_divisor  = cmd.div_mean ? bsize_reg : FRAME_W'(c_raw);

    mmcd_div #(
        .W    (DIV_W),
        .DV_W (FRAME_W),
        .QW   (QW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_q),
        .remainder (div_r),
        .busy      (div_busy),
        .done      (div_done)
    );

    assign status.restart  = cfg_write && ((cfg_index == mmcd_pkg::REG_SAMPLE_COUNT)
                             || (cfg_index == mmcd_pkg::REG_COLUMN_COUNT));
    assign status.close    = close;
    assign status.avg      = display_mode_reg;
    assign status.out_free = !out_valid_reg || out_ready;
    assign status.div_busy = div_busy;
    assign status.div_done = div_done;

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_min   = out_min_reg;
    assign out_max   = out_max_reg;
    assign out_mean  = out_mean_reg;
    assign out_last  = out_last_reg;
    assign out_rail  = out_rail_reg;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

    localparam int IN_W          = 16;
    localparam int OUT_W         = 48;
    localparam int MAX_COLS      = 2048;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 14;
    localparam int PHASE_ITEMS   = 115;

    typedef struct packed {
        logic [10:0] index;
        logic [11:0] col_min;
        logic [11:0] col_max;
        logic [11:0] col_mean;
        logic        is_last;
        logic        noise;
    } column_t;

    typedef struct {
        logic [IN_W-1:0] word;
        bit              drain;
    } sample_item_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [IN_W-1:0]                  s_axis_tdata = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [OUT_W-1:0]                 m_axis_tdata;
    logic                             m_axis_tlast;
    logic                             m_axis_tuser;
    logic                             cfg_write = 1'b0;
    logic [mmcd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [mmcd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    sample_item_t sample_q[$];
    column_t      column_q[$];
    bit           idle_on = 1'b1;
    int           send_gap = 0;
    int           hold_left = 0;
    int           mismatches = 0;

    // register mirror
    logic [15:0] cfg_samples;
    logic [11:0] cfg_columns;
    logic        cfg_avg;
    logic [11:0] cfg_span;

    // decimator state
    logic [15:0] frame_pos;
    logic [10:0] col_idx;
    logic [15:0] bnd_rem;
    logic [15:0] bnd_end;
    logic [11:0] bkt_min;
    logic [11:0] bkt_max;
    logic [27:0] bkt_sum;
    logic [15:0] bkt_len;
    logic [11:0] frm_min;
    logic [11:0] frm_max;

    minmax_column_decimator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] frame_len();
        return (cfg_samples == 16'd0) ? 16'd1 : cfg_samples;
    endfunction

    function automatic logic [15:0] column_total();
        logic [15:0] c;
        c = (cfg_columns == 12'd0) ? 16'd1 : {4'd0, cfg_columns};
        if (c > 16'(MAX_COLS))
            c = 16'(MAX_COLS);
        if (c > frame_len())
            c = frame_len();
        return c;
    endfunction

    function automatic void clear_bucket();
        bkt_min = 12'hFFF;
        bkt_max = '0;
        bkt_sum = '0;
        bkt_len = '0;
    endfunction

    function automatic void start_frame();
        frame_pos = '0;
        col_idx   = '0;
        bnd_end   = frame_len() / column_total();
        bnd_rem   = frame_len() % column_total();
        frm_min   = 12'hFFF;
        frm_max   = '0;
        clear_bucket();
    endfunction

    // folds one sample into the current column, returns 1 when the column closes
    function automatic bit decimate_sample(input logic [11:0] v, output column_t r);
        logic [15:0] c;
        logic        is_last;
        c = column_total();
        r = '0;
        if (v < bkt_min) bkt_min = v;
        if (v > bkt_max) bkt_max = v;
        if (v < frm_min) frm_min = v;
        if (v > frm_max) frm_max = v;
        bkt_sum   = bkt_sum + 28'(v);
        bkt_len   = bkt_len + 16'd1;
        frame_pos = frame_pos + 16'd1;
        if (frame_pos < bnd_end)
            return 1'b0;
        is_last    = ({5'd0, col_idx} + 16'd1 >= c);
        r.index    = col_idx;
        r.col_min  = bkt_min;
        r.col_max  = bkt_max;
        r.col_mean = (cfg_avg && bkt_len != 0) ? 12'(bkt_sum / bkt_len) : 12'd0;
        r.is_last  = is_last;
        r.noise    = is_last && (frm_max >= frm_min) && ((frm_max - frm_min) > cfg_span);
        if (is_last)
            start_frame();
        else
        begin
            col_idx = col_idx + 11'd1;
            clear_bucket();
            bnd_end = bnd_end + frame_len() / c;
            bnd_rem = bnd_rem + frame_len() % c;
            if (bnd_rem >= c)
            begin
                bnd_rem = bnd_rem - c;
                bnd_end = bnd_end + 16'd1;
            end
        end
        return 1'b1;
    endfunction

    // sample driver
    always @(posedge clk)
    begin
        column_t      r;
        sample_item_t nxt;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (decimate_sample(s_axis_tdata[11:0], r))
                    column_q.insert(column_q.size(), r);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (sample_q.size() != 0 && !(sample_q[0].drain && column_q.size() != 0))
                begin
                    nxt = sample_q.pop_front();
                    s_axis_tdata  <= nxt.word;
                    s_axis_tvalid <= 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 11);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // column monitor
    always @(posedge clk)
    begin
        column_t got;
        column_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.index    = m_axis_tdata[10:0];
                got.col_min  = m_axis_tdata[22:11];
                got.col_max  = m_axis_tdata[34:23];
                got.col_mean = m_axis_tdata[46:35];
                got.is_last  = m_axis_tlast;
                got.noise    = m_axis_tuser;
                if (column_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no column, actual idx=%0d min=%0d max=%0d mean=%0d",
                             $realtime, got.index, got.col_min, got.col_max, got.col_mean);
                end
                else
                begin
                    want = column_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        $display("%0t: expected idx=%0d min=%0d max=%0d mean=%0d last=%0b rail=%0b",
                                 $realtime, want.index, want.col_min, want.col_max,
                                 want.col_mean, want.is_last, want.noise);
                        $display("%0t:   actual idx=%0d min=%0d max=%0d mean=%0d last=%0b rail=%0b",
                                 $realtime, got.index, got.col_min, got.col_max,
                                 got.col_mean, got.is_last, got.noise);
                    end
                end
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                hold_left = $urandom_range(0, 10);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        #5_000_000;
        $display("minmax_column_decimator_core: mismatch");
        $finish;
    end

    task automatic add_sample(input logic [IN_W-1:0] word, input bit drain = 1'b0);
        sample_item_t it;
        it.word  = word;
        it.drain = drain;
        sample_q.insert(sample_q.size(), it);
    endtask

    task automatic wait_drained();
        while (sample_q.size() != 0 || s_axis_tvalid || column_q.size() != 0)
            @(posedge clk);
    endtask

    // the block may still be closing a column or sizing the frame
    task automatic write_register(input logic [mmcd_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [mmcd_pkg::CFG_DATA_W-1:0] val);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            mmcd_pkg::REG_SAMPLE_COUNT:
            begin
                cfg_samples = val;
                start_frame();
            end
            mmcd_pkg::REG_COLUMN_COUNT:
            begin
                cfg_columns = val[11:0];
                start_frame();
            end
            mmcd_pkg::REG_DISPLAY_MODE: cfg_avg = val[0];
            mmcd_pkg::REG_NOISE_SPAN:   cfg_span = val[11:0];
            default: ;
        endcase
    endtask

    function automatic logic [IN_W-1:0] random_word();
        logic [11:0] v;
        logic [3:0]  pad;
        case ($urandom_range(0, 9))
            0: v = 12'd0;
            1: v = 12'hFFF;
            2: v = 12'($urandom_range(0, 15));
            3: v = 12'hFFF - 12'($urandom_range(0, 15));
            default: v = 12'($urandom);
        endcase
        pad = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'd0;
        return {pad, v};
    endfunction

    initial
    begin
        logic [mmcd_pkg::CFG_DATA_W-1:0] val;
        int ph;
        int n;
        cfg_samples = mmcd_pkg::SAMPLE_COUNT_RST;
        cfg_columns = mmcd_pkg::COLUMN_COUNT_RST;
        cfg_avg     = mmcd_pkg::DISPLAY_MODE_RST;
        cfg_span    = mmcd_pkg::NOISE_SPAN_RST;
        start_frame();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, envelope only, extremes and ignored upper bits
        add_sample(16'h0000);
        add_sample(16'h0FFF);
        add_sample(16'hFFFF);
        add_sample(16'h0800, 1'b1);
        add_sample(16'h0001);
        add_sample(16'hAFFE);
        wait_drained();

        // one column of three samples with mean, zero span limit
        write_register(mmcd_pkg::REG_DISPLAY_MODE, 16'hFFFF);
        write_register(mmcd_pkg::REG_NOISE_SPAN, 16'h0000);
        write_register(mmcd_pkg::REG_SAMPLE_COUNT, 16'd3);
        write_register(mmcd_pkg::REG_COLUMN_COUNT, 16'd0);
        add_sample(16'h0FFF);
        add_sample(16'h0FFF);
        add_sample(16'h0FFE);
        add_sample(16'h0000);
        add_sample(16'h0000);
        add_sample(16'hF000);
        wait_drained();

        // zero sample count, column count saturating then clamped
        write_register(mmcd_pkg::REG_SAMPLE_COUNT, 16'd0);
        write_register(mmcd_pkg::REG_COLUMN_COUNT, 16'hFFFF);
        add_sample(16'h0FFF);
        add_sample(16'h0000);
        wait_drained();

        // more columns than samples, full-scale span at the widest limit
        write_register(mmcd_pkg::REG_NOISE_SPAN, 16'h0FFF);
        write_register(mmcd_pkg::REG_SAMPLE_COUNT, 16'd5);
        write_register(mmcd_pkg::REG_COLUMN_COUNT, 16'd7);
        add_sample(16'h0000);
        add_sample(16'h0FFF);
        add_sample(16'h0800);
        add_sample(16'h0FFF);
        add_sample(16'h0000);
        wait_drained();

        for (ph = 0; ph < PHASES; ph++)
        begin
            idle_on = (ph < PHASES - 3);
            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 9))
                    0: val = 16'hFFFF;
                    1: val = 16'd0;
                    2: val = 16'($urandom_range(41, 400));
                    default: val = 16'($urandom_range(1, 40));
                endcase
                write_register(mmcd_pkg::REG_SAMPLE_COUNT, val);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 9))
                    0: val = 16'd0;
                    1: val = {4'($urandom), 12'hFFF};
                    2: val = 16'd2048;
                    3: val = 16'($urandom);
                    default: val = 16'($urandom_range(1, 48));
                endcase
                write_register(mmcd_pkg::REG_COLUMN_COUNT, val);
            end
            if ($urandom_range(0, 1) != 0)
                write_register(mmcd_pkg::REG_DISPLAY_MODE, 16'($urandom));
            if ($urandom_range(0, 1) != 0)
            begin
                case ($urandom_range(0, 5))
                    0: val = 16'd0;
                    1: val = 16'h0FFF;
                    default: val = 16'($urandom);
                endcase
                write_register(mmcd_pkg::REG_NOISE_SPAN, val);
            end
            for (n = 0; n < PHASE_ITEMS; n++)
                add_sample(random_word(), $urandom_range(0, 79) == 0);
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && column_q.size() == 0)
            $display("minmax_column_decimator_core: match");
        else
            $display("minmax_column_decimator_core: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/mmcd_pkg.sv
hdl/mmcd_div.sv
hdl/mmcd_ctrl.sv
hdl/mmcd_dp.sv
hdl/minmax_column_decimator_core.sv
tb/tb_top.sv
